// ===== hdl/okvt_pkg.sv =====
// Shared constants and types for the ordered key/value table.
package okvt_pkg;

    localparam int DEPTH   = 16;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int CMP_W   = (CNT_W > 4) ? CNT_W : 4;
    localparam int KEY_W   = 16;
    localparam int SPEED_W = 16;
    localparam int ENTRY_W = KEY_W + SPEED_W;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_REMOVE = 2'd1,
        OP_READ   = 2'd2,
        OP_LOOKUP = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SCAN,
        ST_SHIFT,
        ST_DONE
    } state_t;

endpackage

// ===== hdl/okvt_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module okvt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/ordered_key_value_table.sv =====
// Ordered (id, speed) table with append, remove with compaction, read and lookup.
//
//   channel | direction | ports                                          | handshake
//   --------+-----------+------------------------------------------------+----------------
//   s_      | in        | s_op s_key_id s_value_speed s_position         | s_valid/s_ready
//   m_      | out       | m_ok m_out_id m_out_speed m_out_position       | m_valid/m_ready
//           |           | m_entry_count                                  |
//
// Append writes the RAM as the request is taken; an in-range read passes through ST_READ for the
// registered RAM read. Lookup scans one entry a cycle through the RAM read port. Remove then
// moves each later entry down one place through the RAM read pipeline and drops the count.
// One request is in work at a time; s_ready is high only when the sequencer is idle.
// The result register lets the next request enter while a result waits for m_ready.
// Reset (aresetn, synchronous) empties the table; the RAM contents need no clearing.
module ordered_key_value_table (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_op,
    input  logic [15:0] s_key_id,
    input  logic [15:0] s_value_speed,
    input  logic [3:0]  s_position,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_ok,
    output logic [15:0] m_out_id,
    output logic [15:0] m_out_speed,
    output logic [3:0]  m_out_position,
    output logic [4:0]  m_entry_count
);
    import okvt_pkg::*;

    state_t             state_reg,     state_next;
    op_t                op_reg,        op_next;
    logic [KEY_W-1:0]   key_reg,       key_next;
    logic [CNT_W-1:0]   count_reg,     count_next;
    logic [CNT_W-1:0]   rd_idx_reg,    rd_idx_next;
    logic               cmp_vld_reg,   cmp_vld_next;
    logic [IDX_W-1:0]   cmp_idx_reg,   cmp_idx_next;
    logic               pend_reg,      pend_next;
    logic [IDX_W-1:0]   wr_idx_reg,    wr_idx_next;
    logic               res_ok_reg,    res_ok_next;
    logic [KEY_W-1:0]   res_id_reg,    res_id_next;
    logic [SPEED_W-1:0] res_speed_reg, res_speed_next;
    logic [IDX_W-1:0]   res_pos_reg,   res_pos_next;
    logic               m_valid_reg,   m_valid_next;
    logic               m_ok_reg;
    logic [15:0]        m_id_reg;
    logic [15:0]        m_speed_reg;
    logic [3:0]         m_pos_reg;
    logic [4:0]         m_count_reg;

    logic               s_fire;
    logic               out_load;
    op_t                s_op_t;
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [KEY_W-1:0]   rd_id;
    logic [SPEED_W-1:0] rd_speed;
    logic               scan_hit;
    logic               scan_last;
    logic               issue_ok;
    logic               read_in_range;
    logic               not_full;

    okvt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign s_ready       = (state_reg == ST_IDLE);
    assign s_fire        = s_valid && s_ready;
    assign s_op_t        = op_t'(s_op);
    assign out_load      = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);
    assign rd_id         = ram_rdata[ENTRY_W-1:SPEED_W];
    assign rd_speed      = ram_rdata[SPEED_W-1:0];
    assign scan_hit      = cmp_vld_reg && (rd_id == key_reg);
    assign scan_last     = cmp_vld_reg && (CNT_W'(cmp_idx_reg) == count_reg - CNT_W'(1));
    assign issue_ok      = (rd_idx_reg < count_reg);
    assign read_in_range = (CMP_W'(s_position) < CMP_W'(count_reg));
    assign not_full      = (count_reg < CNT_W'(DEPTH));

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    unique case (s_op_t)
                        OP_APPEND: state_next = ST_DONE;
                        OP_READ:   state_next = read_in_range ? ST_READ : ST_DONE;
                        OP_REMOVE,
                        OP_LOOKUP: state_next = (count_reg != '0) ? ST_SCAN : ST_DONE;
                        default:   state_next = ST_DONE;
                    endcase
                end
            end
            ST_READ: state_next = ST_DONE;
            ST_SCAN: begin
                if (scan_hit) begin
                    state_next = (op_reg == OP_REMOVE) ? ST_SHIFT : ST_DONE;
                end else if (scan_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_SHIFT: begin
                if (!issue_ok && !pend_reg) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and RAM control
    always_comb begin
        op_next        = op_reg;
        key_next       = key_reg;
        count_next     = count_reg;
        rd_idx_next    = rd_idx_reg;
        cmp_vld_next   = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        pend_next      = 1'b0;
        wr_idx_next    = wr_idx_reg;
        res_ok_next    = res_ok_reg;
        res_id_next    = res_id_reg;
        res_speed_next = res_speed_reg;
        res_pos_next   = res_pos_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;
        ram_raddr      = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    op_next        = s_op_t;
                    key_next       = s_key_id;
                    rd_idx_next    = '0;
                    res_ok_next    = 1'b0;
                    res_id_next    = '0;
                    res_speed_next = '0;
                    res_pos_next   = '0;
                    unique case (s_op_t)
                        OP_APPEND: begin
                            if (not_full) begin
                                ram_we         = 1'b1;
                                ram_waddr      = IDX_W'(count_reg);
                                ram_wdata      = {s_key_id, s_value_speed};
                                count_next     = count_reg + CNT_W'(1);
                                res_ok_next    = 1'b1;
                                res_id_next    = s_key_id;
                                res_speed_next = s_value_speed;
                                res_pos_next   = IDX_W'(count_reg);
                            end
                        end
                        OP_READ: begin
                            ram_raddr = IDX_W'(s_position);
                            if (read_in_range) begin
                                res_pos_next = IDX_W'(s_position);
                            end
                        end
                        OP_REMOVE,
                        OP_LOOKUP: begin
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_READ: begin
                res_ok_next    = 1'b1;
                res_id_next    = rd_id;
                res_speed_next = rd_speed;
            end
            ST_SCAN: begin
                if (issue_ok) begin
                    ram_raddr    = IDX_W'(rd_idx_reg);
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = IDX_W'(rd_idx_reg);
                    rd_idx_next  = rd_idx_reg + CNT_W'(1);
                end
                if (scan_hit) begin
                    res_ok_next    = 1'b1;
                    res_id_next    = rd_id;
                    res_speed_next = rd_speed;
                    res_pos_next   = cmp_idx_reg;
                    rd_idx_next    = CNT_W'(cmp_idx_reg) + CNT_W'(1);
                    cmp_vld_next   = 1'b0;
                end
            end
            ST_SHIFT: begin
                // read entry i + 1, write it to i in the next cycle
                if (issue_ok) begin
                    ram_raddr   = IDX_W'(rd_idx_reg);
                    pend_next   = 1'b1;
                    wr_idx_next = IDX_W'(rd_idx_reg - CNT_W'(1));
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                end
                if (pend_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = wr_idx_reg;
                    ram_wdata = ram_rdata;
                end
                if (!issue_ok && !pend_reg) begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            cmp_vld_reg <= 1'b0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            cmp_vld_reg <= cmp_vld_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        key_reg       <= key_next;
        rd_idx_reg    <= rd_idx_next;
        cmp_idx_reg   <= cmp_idx_next;
        wr_idx_reg    <= wr_idx_next;
        res_ok_reg    <= res_ok_next;
        res_id_reg    <= res_id_next;
        res_speed_reg <= res_speed_next;
        res_pos_reg   <= res_pos_next;
        if (out_load) begin
            m_ok_reg    <= res_ok_reg;
            m_id_reg    <= res_id_reg;
            m_speed_reg <= res_speed_reg;
            m_pos_reg   <= 4'(res_pos_reg);
            m_count_reg <= 5'(count_reg);
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_ok           = m_ok_reg;
    assign m_out_id       = m_id_reg;
    assign m_out_speed    = m_speed_reg;
    assign m_out_position = m_pos_reg;
    assign m_entry_count  = m_count_reg;

endmodule
